@@ hdl/rc4_pkg.sv @@
// Shared constants for the RC4 engine: permutation size, permutation address width,
// operation codes and the default key store depth. No dependencies.
`default_nettype none

package rc4_pkg;

    localparam int PERM_SIZE         = 256;
    localparam int PERM_AW           = 8;
    localparam int DEF_MAX_KEY_BYTES = 256;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_DATA = 1'b1;

endpackage

`default_nettype wire

@@ hdl/rc4_ram.sv @@
// Generic single-write, single-read RAM with registered read data (read-first).
// Stand-alone, no package dependency.
`default_nettype none

module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hdl/rc4_stream_cipher_top.sv @@
// RC4 engine top level: key store, permutation memory, sequencer, one shared adder.
// Depends on rc4_pkg and rc4_ram.
// A key byte not marked last is only stored. A data byte runs 4 sequencer steps (D_SY, D_WX, D_WY,
// D_OUT) on the one-read, one-write permutation memory; D_OUT loads the result register unless stalled.
// Final key byte: identity fill of all 256 entries, then 256 swaps through KS_RD, KS_J, KS_WI, KS_WJ.
// Reset (rst_n low, asynchronous) clears control state and starts the identity fill of all
// 256 entries; no word is accepted until it completes.
`default_nettype none

module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic       op,
    input  wire logic [7:0] value,
    input  wire logic       last,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic      [7:0] data_out
);

    localparam int KEY_AW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam int KEY_CW = $clog2(MAX_KEY_BYTES + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_FILL  = 4'd1;
    localparam logic [3:0] ST_KS_RD = 4'd2;
    localparam logic [3:0] ST_KS_J  = 4'd3;
    localparam logic [3:0] ST_KS_WI = 4'd4;
    localparam logic [3:0] ST_KS_WJ = 4'd5;
    localparam logic [3:0] ST_D_SY  = 4'd6;
    localparam logic [3:0] ST_D_WX  = 4'd7;
    localparam logic [3:0] ST_D_WY  = 4'd8;
    localparam logic [3:0] ST_D_OUT = 4'd9;

    // control state
    logic [3:0]        state_reg, state_next;
    logic              sched_reg, sched_next;
    logic [KEY_CW-1:0] count_reg, count_next;
    logic [7:0]        x_reg, x_next;
    logic [7:0]        y_reg, y_next;
    logic              out_valid_reg, out_valid_next;

    // datapath
    logic [PERM_AW-1:0] i_reg, i_next;
    logic [7:0]         j_reg, j_next;
    logic [KEY_AW-1:0]  kidx_reg, kidx_next;
    logic [KEY_CW-1:0]  len_reg, len_next;
    logic [7:0]         si_reg, si_next;
    logic [7:0]         sj_reg, sj_next;
    logic [7:0]         val_reg, val_next;
    logic               fwd_reg, fwd_next;
    logic [7:0]         dout_reg, dout_next;

    // permutation memory ports
    logic               p_we;
    logic [PERM_AW-1:0] p_waddr, p_raddr;
    logic [7:0]         p_wdata, p_rdata;

    // key store ports
    logic               k_we;
    logic [KEY_AW-1:0]  k_waddr;
    logic [7:0]         k_rdata;

    // shared adder
    logic [7:0] add_a, add_b, add_c, add_sum;

    logic              in_acc;
    logic              room;
    logic [KEY_CW-1:0] count_inc;
    logic [KEY_CW-1:0] kidx_inc;
    logic [7:0]        ks_byte;

    assign add_sum   = add_a + add_b + add_c;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign room      = (count_reg < KEY_CW'(MAX_KEY_BYTES));
    assign count_inc = count_reg + KEY_CW'(1);
    assign kidx_inc  = KEY_CW'(kidx_reg) + KEY_CW'(1);
    assign ks_byte   = fwd_reg ? si_reg : p_rdata;

    assign k_we    = in_acc && (op == OP_KEY) && room;
    assign k_waddr = count_reg[KEY_AW-1:0];

    assign out_valid = out_valid_reg;
    assign data_out  = dout_reg;

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (PERM_SIZE)
    ) u_perm (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    rc4_ram #(
        .WIDTH (8),
        .DEPTH (MAX_KEY_BYTES)
    ) u_key (
        .clk   (clk),
        .we    (k_we),
        .waddr (k_waddr),
        .wdata (value),
        .raddr (kidx_reg),
        .rdata (k_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        sched_next     = sched_reg;
        count_next     = count_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        out_valid_next = out_valid_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        kidx_next      = kidx_reg;
        len_next       = len_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        val_next       = val_reg;
        fwd_next       = fwd_reg;
        dout_next      = dout_reg;

        p_we    = 1'b0;
        p_waddr = i_reg;
        p_wdata = i_reg;
        p_raddr = x_reg + 8'd1;
        add_a   = y_reg;
        add_b   = p_rdata;
        add_c   = 8'd0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (op == OP_DATA)
                    begin
                        x_next     = x_reg + 8'd1;
                        val_next   = value;
                        state_next = ST_D_SY;
                    end
                    else
                    begin
                        count_next = room ? count_inc : count_reg;
                        if (last)
                        begin
                            len_next   = room ? count_inc : count_reg;
                            count_next = '0;
                            sched_next = 1'b1;
                            x_next     = 8'd0;
                            y_next     = 8'd0;
                            i_next     = '0;
                            state_next = ST_FILL;
                        end
                    end
                end
            end
            ST_FILL:
            begin
                p_we   = 1'b1;
                i_next = i_reg + PERM_AW'(1);
                if (i_reg == PERM_AW'(PERM_SIZE - 1))
                begin
                    j_next     = 8'd0;
                    kidx_next  = '0;
                    sched_next = 1'b0;
                    state_next = sched_reg ? ST_KS_RD : ST_IDLE;
                end
            end
            ST_KS_RD:
            begin
                p_raddr    = i_reg;
                state_next = ST_KS_J;
            end
            ST_KS_J:
            begin
                // j += S[i] + key byte
                add_a      = j_reg;
                add_c      = k_rdata;
                si_next    = p_rdata;
                j_next     = add_sum;
                p_raddr    = add_sum;
                state_next = ST_KS_WI;
            end
            ST_KS_WI:
            begin
                p_we       = 1'b1;
                p_waddr    = i_reg;
                p_wdata    = p_rdata;
                state_next = ST_KS_WJ;
            end
            ST_KS_WJ:
            begin
                p_we      = 1'b1;
                p_waddr   = j_reg;
                p_wdata   = si_reg;
                i_next    = i_reg + PERM_AW'(1);
                kidx_next = (kidx_inc == len_reg) ? '0 : kidx_inc[KEY_AW-1:0];
                state_next = (i_reg == PERM_AW'(PERM_SIZE - 1)) ? ST_IDLE : ST_KS_RD;
            end
            ST_D_SY:
            begin
                // sx arrives; y += sx
                si_next    = p_rdata;
                y_next     = add_sum;
                p_raddr    = add_sum;
                state_next = ST_D_WX;
            end
            ST_D_WX:
            begin
                sj_next    = p_rdata;
                p_we       = 1'b1;
                p_waddr    = x_reg;
                p_wdata    = p_rdata;
                state_next = ST_D_WY;
            end
            ST_D_WY:
            begin
                // keystream read overlaps the write of S[y]; forward sx on a hit
                p_we       = 1'b1;
                p_waddr    = y_reg;
                p_wdata    = si_reg;
                add_a      = si_reg;
                add_b      = sj_reg;
                p_raddr    = add_sum;
                fwd_next   = (add_sum == y_reg);
                state_next = ST_D_OUT;
            end
            ST_D_OUT:
            begin
                add_a   = si_reg;
                add_b   = sj_reg;
                p_raddr = add_sum;
                if (!out_valid_reg || !out_stall)
                begin
                    dout_next      = val_reg ^ ks_byte;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            sched_reg     <= 1'b0;
            count_reg     <= '0;
            x_reg         <= 8'd0;
            y_reg         <= 8'd0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sched_reg     <= sched_next;
            count_reg     <= count_next;
            x_reg         <= x_next;
            y_reg         <= y_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg    <= j_next;
        kidx_reg <= kidx_next;
        len_reg  <= len_next;
        si_reg   <= si_next;
        sj_reg   <= sj_next;
        val_reg  <= val_next;
        fwd_reg  <= fwd_next;
        dout_reg <= dout_next;
    end

endmodule

`default_nettype wire

@@ hdl/rc4_checker.sv @@
// Port-level checks for the RC4 engine, bound to the top level.
// Depends on rc4_pkg.
`default_nettype none

module rc4_checker
    import rc4_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       op,
    input wire logic [7:0] value,
    input wire logic       last,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] data_out
);

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    // stalled result word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(data_out))
        else $error("result word dropped or changed while stalled");

    // data word occupies the engine
    a_data_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (op == OP_DATA) |=> in_stall)
        else $error("data word accepted without busy period");

    // plain key byte only fills the store
    a_key_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (op == OP_KEY) && !last |=> !in_stall)
        else $error("key byte not marked last stalled the input");

    // final key byte starts the schedule
    a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (op == OP_KEY) && last |=> in_stall ##1 in_stall)
        else $error("key schedule did not hold off input");

    // a key byte never yields a result on its own
    a_key_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (op == OP_KEY) && !out_valid |=> !out_valid)
        else $error("result word after a key byte");

endmodule

bind rc4_stream_cipher_top rc4_checker u_rc4_checker (.*);

`default_nettype wire
